FILE: rtl/scf_pkg.sv
// Shared modes, byte codes and tracker status type for the string class filter.
`timescale 1ns / 1ps
`default_nettype none

package scf_pkg;

    localparam int MODE_WIDTH = 4;

    // filter mode codes; codes above MODE_NONASCII behave as MODE_NONE
    localparam logic [MODE_WIDTH-1:0] MODE_NONE      = 4'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_UPPER     = 4'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_PRINTABLE = 4'd2;
    localparam logic [MODE_WIDTH-1:0] MODE_EMAIL     = 4'd3;
    localparam logic [MODE_WIDTH-1:0] MODE_FORMAT    = 4'd4;
    localparam logic [MODE_WIDTH-1:0] MODE_URL       = 4'd5;
    localparam logic [MODE_WIDTH-1:0] MODE_IPV4      = 4'd6;
    localparam logic [MODE_WIDTH-1:0] MODE_PATH      = 4'd7;
    localparam logic [MODE_WIDTH-1:0] MODE_NONASCII  = 4'd8;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_TAB_ESC   = 8'h74; // 't'
    localparam logic [7:0] CH_NL_ESC    = 8'h6E; // 'n'
    localparam logic [7:0] CH_CR_ESC    = 8'h72; // 'r'
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TILDE     = 8'h7E;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_AT        = 8'h40;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_PERCENT   = 8'h25;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_Z   = 8'h7A;

    localparam int SEG_WIDTH = 9;
    localparam logic [SEG_WIDTH-1:0] SEG_LIMIT = 9'd256;

    typedef struct packed {
        logic       fail;
        logic       upper;
        logic       at;
        logic       dot;
        logic       percent;
        logic       scheme;
        logic       high;
        logic       ipv4;
        logic [7:0] first_char;
    } trk_flags_t;

endpackage

`default_nettype wire

FILE: rtl/scf_track.sv
// Per-string tracker state: character rules, byte counters and pattern scanners.
`timescale 1ns / 1ps
`default_nettype none

module scf_track
    import scf_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   take,
    input  wire logic                   clear,
    input  wire logic [7:0]             char_byte,
    input  wire logic [MODE_WIDTH-1:0]  mode,
    output trk_flags_t                  flags,
    output logic [COUNT_WIDTH-1:0]      char_count,
    output logic [COUNT_WIDTH-1:0]      first_count,
    output logic [COUNT_WIDTH-1:0]      second_count
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_ONE;
    endfunction

    trk_flags_t             flags_reg, flags_next;
    logic                   esc_reg, esc_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [COUNT_WIDTH-1:0] first_cnt_reg, first_cnt_next;
    logic [COUNT_WIDTH-1:0] second_cnt_reg, second_cnt_next;
    logic [7:0]             second_char_reg, second_char_next;
    logic [7:0]             prev_reg, prev_next;
    logic [7:0]             prev2_reg, prev2_next;
    logic [1:0]             dseg_reg, dseg_next;
    logic [SEG_WIDTH-1:0]   seg_reg, seg_next;
    logic                   digit_reg, digit_next;

    logic        num_byte;
    logic        skip;
    logic [11:0] seg_sum;

    assign num_byte = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
    assign skip     = (char_byte == CH_SPACE) ||
                      (esc_reg && ((char_byte == CH_TAB_ESC) || (char_byte == CH_NL_ESC) ||
                                   (char_byte == CH_CR_ESC)));
    // segment * 10 + digit; fits in 12 bits since the segment stays at or below 256
    assign seg_sum  = {seg_reg, 3'b000} + {2'b00, seg_reg, 1'b0} +
                      {8'h00, char_byte[3:0] - CH_ZERO[3:0]};

    always_comb
    begin
        flags_next       = flags_reg;
        esc_next         = esc_reg;
        count_next       = count_reg;
        first_cnt_next   = first_cnt_reg;
        second_cnt_next  = second_cnt_reg;
        second_char_next = second_char_reg;
        prev_next        = prev_reg;
        prev2_next       = prev2_reg;
        dseg_next        = dseg_reg;
        seg_next         = seg_reg;
        digit_next       = digit_reg;
        if (clear)
        begin
            flags_next       = '0;
            esc_next         = 1'b0;
            count_next       = '0;
            first_cnt_next   = '0;
            second_cnt_next  = '0;
            second_char_next = '0;
            prev_next        = '0;
            prev2_next       = '0;
            dseg_next        = '0;
            seg_next         = '0;
            digit_next       = 1'b0;
        end
        else if (take)
        begin
            if (mode == MODE_UPPER)
            begin
                if (!skip)
                begin
                    if (char_byte[7] || ((char_byte >= CH_LOWER_A) && (char_byte <= CH_LOWER_Z)))
                        flags_next.fail = 1'b1;
                    if ((char_byte >= CH_UPPER_A) && (char_byte <= CH_UPPER_Z))
                        flags_next.upper = 1'b1;
                end
            end
            else if (mode == MODE_PRINTABLE)
            begin
                if ((char_byte < CH_SPACE) || (char_byte > CH_TILDE))
                    flags_next.fail = 1'b1;
            end
            esc_next = esc_reg ? 1'b0 : (char_byte == CH_BACKSLASH);

            if (count_reg == '0)
            begin
                flags_next.first_char = char_byte;
                first_cnt_next        = CNT_ONE;
            end
            else
            begin
                if (char_byte == flags_reg.first_char)
                    first_cnt_next = sat_inc(first_cnt_reg);
                if (count_reg == CNT_ONE)
                begin
                    second_char_next = char_byte;
                    second_cnt_next  = CNT_ONE;
                end
                else if (char_byte == second_char_reg)
                begin
                    second_cnt_next = sat_inc(second_cnt_reg);
                end
                if (char_byte == CH_AT)      flags_next.at      = 1'b1;
                if (char_byte == CH_DOT)     flags_next.dot     = 1'b1;
                if (char_byte == CH_PERCENT) flags_next.percent = 1'b1;
            end

            if ((prev2_reg == CH_COLON) && (prev_reg == CH_SLASH) && (char_byte == CH_SLASH))
                flags_next.scheme = 1'b1;
            if (char_byte[7])
                flags_next.high = 1'b1;

            // dotted quad scanner
            if (num_byte)
            begin
                seg_next   = (seg_sum > {3'b000, SEG_LIMIT}) ? SEG_LIMIT : seg_sum[SEG_WIDTH-1:0];
                digit_next = 1'b1;
                if (dseg_reg == 2'd3)
                    flags_next.ipv4 = 1'b1;
            end
            else if (char_byte == CH_DOT)
            begin
                if (digit_reg && (seg_reg < SEG_LIMIT))
                begin
                    if (dseg_reg != 2'd3)
                        dseg_next = dseg_reg + 2'd1;
                end
                else
                begin
                    dseg_next = '0;
                end
                seg_next   = '0;
                digit_next = 1'b0;
            end
            else
            begin
                seg_next   = '0;
                dseg_next  = '0;
                digit_next = 1'b0;
            end

            prev2_next = prev_reg;
            prev_next  = char_byte;
            count_next = sat_inc(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg       <= '0;
            esc_reg         <= 1'b0;
            count_reg       <= '0;
            first_cnt_reg   <= '0;
            second_cnt_reg  <= '0;
            second_char_reg <= '0;
            prev_reg        <= '0;
            prev2_reg       <= '0;
            dseg_reg        <= '0;
            seg_reg         <= '0;
            digit_reg       <= 1'b0;
        end
        else
        begin
            flags_reg       <= flags_next;
            esc_reg         <= esc_next;
            count_reg       <= count_next;
            first_cnt_reg   <= first_cnt_next;
            second_cnt_reg  <= second_cnt_next;
            second_char_reg <= second_char_next;
            prev_reg        <= prev_next;
            prev2_reg       <= prev2_next;
            dseg_reg        <= dseg_next;
            seg_reg         <= seg_next;
            digit_reg       <= digit_next;
        end
    end

    assign flags        = flags_reg;
    assign char_count   = count_reg;
    assign first_count  = first_cnt_reg;
    assign second_count = second_cnt_reg;

endmodule

`default_nettype wire

FILE: rtl/string_class_filter_top.sv
// Top level of the string class filter: input channel, verdict and result register.
//
// Usage:
//   Stream a string into char_byte one byte per transfer (in_valid/in_stall); a
//   zero byte ends the string. Non-zero bytes only update the trackers and give
//   no result. The terminator gives exactly one result transfer on keep
//   (out_valid/out_stall): 1 when the string passes the filter in the stored mode.
//   Select the mode with cfg_wr_en/cfg_wr_data while the block is idle; the mode
//   survives across strings, every tracker clears after each terminator.
// Timing:
//   One byte per cycle but for held-off terminators; one tracker update per byte.
//   keep shows up one cycle after the terminator transfer, from the result
//   register. Throughput 1 item per cycle while no terminator is held off.
// Stall:
//   While a result waits under out_stall, non-zero bytes still go in; only a
//   further terminator is held off (in_stall high) until the result leaves.
// Reset:
//   rst_n clears the mode to "none", all trackers and the result register.
//   Counters saturate at 2**COUNT_WIDTH-1.
`timescale 1ns / 1ps
`default_nettype none

module string_class_filter_top
    import scf_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [MODE_WIDTH-1:0] cfg_wr_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            char_byte,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       keep
);

    // cnt*5 >= len*3 with len nonzero, done with shifts and adds
    function automatic logic ratio_high(input logic [COUNT_WIDTH-1:0] cnt,
                                        input logic [COUNT_WIDTH-1:0] len);
        logic [COUNT_WIDTH+2:0] cnt5;
        logic [COUNT_WIDTH+2:0] len3;
        cnt5 = {3'b000, cnt} + {1'b0, cnt, 2'b00};
        len3 = {3'b000, len} + {2'b00, len, 1'b0};
        return (len != '0) && (cnt5 >= len3);
    endfunction

    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

    logic [MODE_WIDTH-1:0]  mode_reg;
    logic                   out_valid_reg, out_valid_next;
    logic                   keep_reg, keep_next;

    logic                   in_xfer;
    logic                   term_xfer;
    logic                   byte_xfer;
    logic                   verdict;
    trk_flags_t             flags;
    logic [COUNT_WIDTH-1:0] char_count;
    logic [COUNT_WIDTH-1:0] first_count;
    logic [COUNT_WIDTH-1:0] second_count;

    // hold off a terminator only while the previous result is still stuck
    assign in_stall  = out_valid_reg && out_stall && (char_byte == CH_NUL);
    assign in_xfer   = in_valid && !in_stall;
    assign term_xfer = in_xfer && (char_byte == CH_NUL);
    assign byte_xfer = in_xfer && (char_byte != CH_NUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_NONE;
        else if (cfg_wr_en)
            mode_reg <= cfg_wr_data;
    end

    scf_track #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (byte_xfer),
        .clear        (term_xfer),
        .char_byte    (char_byte),
        .mode         (mode_reg),
        .flags        (flags),
        .char_count   (char_count),
        .first_count  (first_count),
        .second_count (second_count)
    );

    // verdict from the tracker state as it stands before the terminator clears it
    always_comb
    begin
        unique case (mode_reg)
            MODE_UPPER:
                verdict = !flags.fail && !ratio_high(first_count, char_count) &&
                          !((char_count > CNT_ONE) && ratio_high(second_count, char_count)) &&
                          flags.upper;
            MODE_PRINTABLE: verdict = !flags.fail;
            MODE_EMAIL:     verdict = (char_count != '0) && flags.at && flags.dot;
            MODE_FORMAT:    verdict = (char_count != '0) && flags.percent;
            MODE_URL:       verdict = flags.scheme;
            MODE_IPV4:      verdict = flags.ipv4;
            MODE_PATH:      verdict = (char_count != '0) && (flags.first_char == CH_SLASH);
            MODE_NONASCII:  verdict = flags.high;
            default:        verdict = 1'b1;
        endcase
    end

    // result register: load on a terminator, drop once the receiver takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        keep_next      = keep_reg;
        if (term_xfer)
        begin
            out_valid_next = 1'b1;
            keep_next      = verdict;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            keep_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            keep_reg      <= keep_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign keep      = keep_reg;

    // a terminator transfer always produces a pending result next cycle
    a_term_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        term_xfer |=> out_valid)
        else $error("terminator transfer without a result");

    // trackers restart after every terminator
    a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
        term_xfer |=> (char_count == '0) && (first_count == '0) && (second_count == '0))
        else $error("trackers not cleared after terminator");

    // per-byte match counts never exceed the string length
    a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
        (first_count <= char_count) && (second_count <= char_count))
        else $error("match count above length");

    // input is only held off while a result is stuck at the output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a waiting result");

endmodule

`default_nettype wire

FILE: test/string_class_filter_checker.sv
// Checker for the string class filter: tracks each string, predicts keep and compares results.
`timescale 1ns / 1ps

module string_class_filter_checker
    import scf_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [MODE_WIDTH-1:0] cfg_wr_data,
    input  wire logic                  in_valid,
    input  wire logic                  in_stall,
    input  wire logic [7:0]            char_byte,
    input  wire logic                  out_valid,
    input  wire logic                  out_stall,
    input  wire logic                  keep,
    output int                         errors,
    output int                         pending
);

    typedef logic [COUNT_WIDTH-1:0] count_t;

    localparam logic [7:0] BYTE_HIGH_MIN = 8'h80;
    // drop when hits/len >= 3/5
    localparam int RATIO_NUM = 3;
    localparam int RATIO_DEN = 5;

    typedef struct packed {
        logic                 fail;
        logic                 upper;
        logic                 esc;
        count_t               len;
        count_t               hits1;
        count_t               hits2;
        logic [7:0]           c1;
        logic [7:0]           c2;
        logic [7:0]           p1;
        logic [7:0]           p2;
        logic                 at;
        logic                 dot;
        logic                 pct;
        logic                 scheme;
        logic                 high;
        logic [1:0]           seg;
        logic [SEG_WIDTH-1:0] seg_val;
        logic                 digit;
        logic                 quad;
    } text_scan_t;

    logic [MODE_WIDTH-1:0] mode_now;
    text_scan_t            scan;
    logic                  verdicts_due[$];
    logic                  want;
    int                    mismatch_count;

    function automatic count_t bump(input count_t c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic logic too_common(input count_t hits, input count_t len);
        return (len != 0) && (64'(hits) * RATIO_DEN >= 64'(len) * RATIO_NUM);
    endfunction

    function automatic text_scan_t scan_byte(input text_scan_t s,
                                             input logic [MODE_WIDTH-1:0] m,
                                             input logic [7:0] b);
        logic skip;
        logic num_byte;
        int   v;
        num_byte = (b >= CH_ZERO) && (b <= CH_NINE);
        if (m == MODE_UPPER)
        begin
            skip = (b == CH_SPACE) ||
                   (s.esc && (b == CH_TAB_ESC || b == CH_NL_ESC || b == CH_CR_ESC));
            if (!skip)
            begin
                if (b >= BYTE_HIGH_MIN || (b >= CH_LOWER_A && b <= CH_LOWER_Z))
                    s.fail = 1'b1;
                if (b >= CH_UPPER_A && b <= CH_UPPER_Z)
                    s.upper = 1'b1;
            end
        end
        else if (m == MODE_PRINTABLE)
        begin
            if (b < CH_SPACE || b > CH_TILDE)
                s.fail = 1'b1;
        end
        s.esc = s.esc ? 1'b0 : (b == CH_BACKSLASH);

        if (s.len == 0)
        begin
            s.c1    = b;
            s.hits1 = 1;
        end
        else
        begin
            if (b == s.c1)
                s.hits1 = bump(s.hits1);
            if (s.len == 1)
            begin
                s.c2    = b;
                s.hits2 = 1;
            end
            else if (b == s.c2)
                s.hits2 = bump(s.hits2);
            if (b == CH_AT)      s.at  = 1'b1;
            if (b == CH_DOT)     s.dot = 1'b1;
            if (b == CH_PERCENT) s.pct = 1'b1;
        end
        if (s.p2 == CH_COLON && s.p1 == CH_SLASH && b == CH_SLASH)
            s.scheme = 1'b1;
        if (b >= BYTE_HIGH_MIN)
            s.high = 1'b1;

        // dotted quad: three terminated segments below the limit, then a digit
        if (num_byte)
        begin
            v = int'(s.seg_val) * 10 + int'(b - CH_ZERO);
            s.seg_val = (v > int'(SEG_LIMIT)) ? SEG_LIMIT : SEG_WIDTH'(v);
            if (s.seg == 2'd3)
                s.quad = 1'b1;
            s.digit = 1'b1;
        end
        else if (b == CH_DOT)
        begin
            if (s.digit && s.seg_val < SEG_LIMIT)
            begin
                if (s.seg != 2'd3)
                    s.seg = s.seg + 1'b1;
            end
            else
                s.seg = 2'd0;
            s.seg_val = '0;
            s.digit   = 1'b0;
        end
        else
        begin
            s.seg_val = '0;
            s.seg     = 2'd0;
            s.digit   = 1'b0;
        end

        s.p2  = s.p1;
        s.p1  = b;
        s.len = bump(s.len);
        return s;
    endfunction

    function automatic logic judge(input text_scan_t s, input logic [MODE_WIDTH-1:0] m);
        case (m)
            MODE_UPPER:     return !s.fail && !too_common(s.hits1, s.len) &&
                                   !(s.len >= 2 && too_common(s.hits2, s.len)) && s.upper;
            MODE_PRINTABLE: return !s.fail;
            MODE_EMAIL:     return (s.len != 0) && s.at && s.dot;
            MODE_FORMAT:    return (s.len != 0) && s.pct;
            MODE_URL:       return s.scheme;
            MODE_IPV4:      return s.quad;
            MODE_PATH:      return (s.len != 0) && (s.c1 == CH_SLASH);
            MODE_NONASCII:  return s.high;
            default:        return 1'b1;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_now       = MODE_NONE;
            scan           = '0;
            mismatch_count = 0;
            verdicts_due.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdicts_due.size() == 0)
                begin
                    $display("%0t: keep result with none expected, expected none actual %0b",
                             $time, keep);
                    mismatch_count++;
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (keep !== want)
                    begin
                        $display("%0t: keep mismatch, expected %0b actual %0b",
                                 $time, want, keep);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (char_byte == CH_NUL)
                begin
                    verdicts_due.push_back(judge(scan, mode_now));
                    scan = '0;
                end
                else
                    scan = scan_byte(scan, mode_now, char_byte);
            end
            if (cfg_wr_en)
                mode_now = cfg_wr_data;
        end
        errors  <= mismatch_count;
        pending <= verdicts_due.size();
    end

endmodule

FILE: test/tb_string_class_filter_top.sv
// Testbench top for the string class filter: clock, reset, byte stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_string_class_filter_top
    import scf_pkg::*;
();

    localparam int TIMEOUT_NS   = 8_000_000;
    localparam int ITEM_TARGET  = 1500;
    localparam int SETTLE_CYCLES = 10;

    localparam logic [MODE_WIDTH-1:0] MODE_SPARE_MAX = 4'hF;
    localparam logic [7:0] BYTE_HIGH_MIN = 8'h80;
    localparam logic [7:0] BYTE_MAX      = 8'hFF;
    localparam logic [7:0] BYTE_DEL      = 8'h7F;
    localparam logic [7:0] BYTE_UNIT_SEP = 8'h1F;
    localparam logic [7:0] BYTE_SOH      = 8'h01;

    // kinds of text fragment the string builder strings together
    typedef enum int {
        P_ANY, P_UPPER, P_LOWER, P_DIGITS, P_DOT, P_AT, P_PERCENT, P_SLASH,
        P_COLON, P_SCHEME, P_ESCAPE, P_SPACE, P_HIGH, P_PRINT, P_QUAD, P_COUNT
    } piece_t;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [MODE_WIDTH-1:0] cfg_wr_data = MODE_NONE;
    logic                  in_valid    = 1'b0;
    logic [7:0]            char_byte   = CH_NUL;
    logic                  out_stall   = 1'b0;
    logic                  in_stall;
    logic                  out_valid;
    logic                  keep;
    int                    fail_total;
    int                    due_count;

    logic [MODE_WIDTH-1:0] mode_sel = MODE_NONE;
    logic [7:0]            text_buf[$];
    int                    sent_bytes = 0;
    logic                  calm = 1'b0;
    int                    strings_left = 0;
    logic                  pressure_done = 1'b0;

    int                    stall_left = 0;
    logic                  stall_state = 1'b0;
    int                    stall_pick;

    always #5 clk = ~clk;

    string_class_filter_top uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_byte  (char_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .keep       (keep)
    );

    string_class_filter_checker scan_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_byte  (char_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .keep       (keep),
        .errors     (fail_total),
        .pending    (due_count)
    );

    // Sender gap: mostly back to back, sometimes a few cycles, rarely long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 8);
        else
            return $urandom_range(10, 40);
    endfunction

    // Receiver: alternate free and stalled runs of random length, with the
    // occasional long stretch of no stalling at all.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 3)
            begin
                stall_state = 1'b0;
                stall_left  = $urandom_range(100, 300);
            end
            else if (stall_pick < 70)
            begin
                stall_state = 1'b0;
                stall_left  = $urandom_range(1, 8);
            end
            else if (stall_pick < 93)
            begin
                stall_state = 1'b1;
                stall_left  = $urandom_range(1, 3);
            end
            else
            begin
                stall_state = 1'b1;
                stall_left  = $urandom_range(10, 40);
            end
        end
        stall_left--;
        out_stall <= stall_state;
    end

    // Present one byte and hold it until the transfer, then maybe idle a while.
    task automatic push_byte(input logic [7:0] b);
        int gap;
        in_valid  <= 1'b1;
        char_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_bytes++;
        gap = calm ? 0 : pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and hold off until every outstanding verdict has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_count != 0)
            @(posedge clk);
    endtask

    // Change the mode only once the block is idle; a byte can give no result,
    // so let the block settle a few cycles after the last verdict.
    task automatic set_mode(input logic [MODE_WIDTH-1:0] m);
        drain();
        repeat (3) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        mode_sel     = m;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Send the built string followed by its terminator.
    task automatic send_buf();
        foreach (text_buf[i])
            push_byte(text_buf[i]);
        push_byte(CH_NUL);
    endtask

    task automatic send_text(input string s);
        text_buf.delete();
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
        send_buf();
    endtask

    // Pick a fragment kind that tends to pass or nearly pass the given mode.
    function automatic piece_t favored_piece(input logic [MODE_WIDTH-1:0] m);
        int r;
        r = $urandom_range(0, 3);
        case (m)
            MODE_UPPER:     return (r < 2) ? P_UPPER : ((r == 2) ? P_SPACE : P_ESCAPE);
            MODE_PRINTABLE: return (r < 3) ? P_PRINT : P_SPACE;
            MODE_EMAIL:     return (r < 2) ? P_LOWER : ((r == 2) ? P_AT : P_DOT);
            MODE_FORMAT:    return (r < 2) ? P_LOWER : P_PERCENT;
            MODE_URL:       return (r == 0) ? P_LOWER : ((r == 1) ? P_SCHEME :
                                   ((r == 2) ? P_COLON : P_SLASH));
            MODE_IPV4:      return (r < 2) ? P_QUAD : ((r == 2) ? P_DIGITS : P_DOT);
            MODE_PATH:      return (r < 2) ? P_SLASH : P_LOWER;
            MODE_NONASCII:  return (r < 2) ? P_HIGH : P_LOWER;
            default:        return piece_t'($urandom_range(0, P_COUNT - 1));
        endcase
    endfunction

    task automatic add_piece(input piece_t kind);
        int    n;
        int    v;
        string digits;
        case (kind)
            P_ANY:     text_buf.push_back(8'($urandom_range(1, BYTE_MAX)));
            P_UPPER:   text_buf.push_back(8'($urandom_range(CH_UPPER_A, CH_UPPER_Z)));
            P_LOWER:   text_buf.push_back(8'($urandom_range(CH_LOWER_A, CH_LOWER_Z)));
            P_DIGITS:
            begin
                // long runs push the segment value into saturation
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
                repeat (n) text_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end
            P_DOT:     text_buf.push_back(CH_DOT);
            P_AT:      text_buf.push_back(CH_AT);
            P_PERCENT: text_buf.push_back(CH_PERCENT);
            P_SLASH:   text_buf.push_back(CH_SLASH);
            P_COLON:   text_buf.push_back(CH_COLON);
            P_SCHEME:
            begin
                text_buf.push_back(CH_COLON);
                text_buf.push_back(CH_SLASH);
                text_buf.push_back(CH_SLASH);
            end
            P_ESCAPE:
            begin
                text_buf.push_back(CH_BACKSLASH);
                case ($urandom_range(0, 3))
                    0:       text_buf.push_back(CH_TAB_ESC);
                    1:       text_buf.push_back(CH_NL_ESC);
                    2:       text_buf.push_back(CH_CR_ESC);
                    default: text_buf.push_back(8'($urandom_range(CH_LOWER_A, CH_LOWER_Z)));
                endcase
            end
            P_SPACE:   text_buf.push_back(CH_SPACE);
            P_HIGH:    text_buf.push_back(8'($urandom_range(BYTE_HIGH_MIN, BYTE_MAX)));
            P_PRINT:   text_buf.push_back(8'($urandom_range(CH_SPACE, CH_TILDE)));
            P_QUAD:
            begin
                // four segments, now and then one out of range
                for (n = 0; n < 4; n++)
                begin
                    v = ($urandom_range(0, 15) == 0) ? $urandom_range(256, 999)
                                                     : $urandom_range(0, 255);
                    digits = $sformatf("%0d", v);
                    for (int i = 0; i < digits.len(); i++)
                        text_buf.push_back(digits[i]);
                    if (n < 3)
                        text_buf.push_back(CH_DOT);
                end
            end
            default: ;
        endcase
    endtask

    // Build one random string: mostly fragments that suit the mode, the rest
    // noise. A few strings are empty and a few are long.
    task automatic build_text(input logic [MODE_WIDTH-1:0] m);
        int r;
        int pieces;
        text_buf.delete();
        r = $urandom_range(0, 99);
        if (r < 8)
            pieces = 0;
        else if (r < 90)
            pieces = $urandom_range(1, 6);
        else
            pieces = $urandom_range(8, 25);
        if (m == MODE_PATH && $urandom_range(0, 1) == 1)
            text_buf.push_back(CH_SLASH);
        repeat (pieces)
            add_piece(($urandom_range(0, 3) != 0) ? favored_piece(m)
                                                   : piece_t'($urandom_range(0, P_COUNT - 1)));
    endtask

    function automatic logic [MODE_WIDTH-1:0] pick_mode();
        if ($urandom_range(0, 99) < 80)
            return MODE_WIDTH'($urandom_range(MODE_NONE, MODE_NONASCII));
        else
            return MODE_WIDTH'($urandom_range(MODE_NONASCII + 1, MODE_SPARE_MAX));
    endfunction

    // Hard stop in case the block hangs.
    initial
    begin
        #(TIMEOUT_NS);
        $display("FAIL string_class_filter_top");
        $finish;
    end

    initial
    begin
        // hold reset, then release it once
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed strings: one to four per mode, around each rule's edge
        set_mode(MODE_NONE);
        send_text("");
        push_byte(BYTE_MAX);
        push_byte(CH_NUL);

        set_mode(MODE_UPPER);
        send_text("AB");
        send_text("A\\tB");
        send_text("AAB");
        send_text("a");

        set_mode(MODE_PRINTABLE);
        send_text("~ ");
        push_byte(BYTE_DEL);
        push_byte(BYTE_UNIT_SEP);
        push_byte(CH_NUL);

        set_mode(MODE_EMAIL);
        send_text("a@b.c");
        send_text("@.");

        set_mode(MODE_FORMAT);
        send_text("%d");
        send_text("a%");

        set_mode(MODE_URL);
        send_text("a://b");

        set_mode(MODE_IPV4);
        send_text("1.2.3.4");
        send_text("256.1.1.1");

        set_mode(MODE_PATH);
        send_text("/x");

        set_mode(MODE_NONASCII);
        push_byte(BYTE_HIGH_MIN);
        push_byte(CH_NUL);

        set_mode(MODE_SPARE_MAX);
        send_text("");
        push_byte(BYTE_SOH);
        push_byte(CH_NUL);

        // switch the mode in the middle of a string: the lowercase byte is
        // taken under the printable rule, the rest under the uppercase rule
        set_mode(MODE_PRINTABLE);
        push_byte(CH_LOWER_A);
        set_mode(MODE_UPPER);
        send_text("Q");

        // random strings, a new mode every few strings
        while (sent_bytes < ITEM_TARGET)
        begin
            if (strings_left == 0)
            begin
                set_mode(pick_mode());
                strings_left = $urandom_range(3, 15);
            end
            calm = ($urandom_range(0, 9) == 0);
            build_text(mode_sel);
            send_buf();
            strings_left--;
            // once, let every verdict come home before sending on
            if (!pressure_done && sent_bytes > ITEM_TARGET / 2)
            begin
                drain();
                pressure_done = 1'b1;
            end
        end

        // wait out the last verdicts, then a few more cycles for strays
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_total == 0 && due_count == 0)
            $display("PASS string_class_filter_top");
        else
            $display("FAIL string_class_filter_top");
        $finish;
    end

endmodule
